// ===== hdl/gkm_pkg.sv =====
// Shared types and constants of the 2-D Mahalanobis Gaussian kernel.
package gkm_pkg;

    localparam int COORD_BITS   = 16;
    localparam int RESULT_BITS  = 16;
    localparam int QUOT_BITS    = 23;
    localparam int NUM_BITS     = 48;
    localparam int DEN_BITS     = 64;
    localparam int U_BITS       = 30;
    localparam int TAYLOR_TERMS = 10;
    localparam int N_BITS       = 8;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;

    typedef enum logic [1:0] {
        REG_VAR_X,
        REG_VAR_Y,
        REG_COV_XY,
        REG_KERNEL_WIDTH
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] offset_x;
        logic signed [COORD_BITS-1:0] offset_y;
    } sample_t;

    typedef struct packed {
        logic [RESULT_BITS-1:0] kernel_value;
        logic                   bad_covariance;
    } result_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]        var_x;
        logic [COORD_BITS-1:0]        var_y;
        logic signed [COORD_BITS-1:0] cov_xy;
        logic [DEN_BITS-1:0]          denom;
        logic                         det_ok;
    } cfg_t;

    typedef struct packed {
        logic bad;
        logic force_zero;
        logic force_full;
    } tag_t;

endpackage

// ===== hdl/gkm_cfg.sv =====
// Configuration registers and the derived denominator det*h^2.
module gkm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [gkm_pkg::COORD_BITS-1:0] cfg_data,
    output gkm_pkg::cfg_t                 cfg
);
    import gkm_pkg::*;

    logic [COORD_BITS-1:0] var_x_reg, var_y_reg, cov_xy_reg, width_reg;
    logic [31:0]           vxvy_reg, cc_reg, hh_reg, hh2_reg;
    logic signed [33:0]    det_reg;
    logic signed [33:0]    det_next;
    logic signed [31:0]    cc_next;
    logic [47:0]           plo_reg, phi_reg;
    logic                  det_ok_reg;
    logic [DEN_BITS-1:0]   denom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_x_reg  <= COORD_BITS'(256);
            var_y_reg  <= COORD_BITS'(256);
            cov_xy_reg <= '0;
            width_reg  <= COORD_BITS'(256);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_VAR_X:        var_x_reg  <= cfg_data;
                REG_VAR_Y:        var_y_reg  <= cfg_data;
                REG_COV_XY:       cov_xy_reg <= cfg_data;
                REG_KERNEL_WIDTH: width_reg  <= cfg_data;
            endcase
        end
    end

    assign cc_next  = $signed(cov_xy_reg) * $signed(cov_xy_reg);
    assign det_next = $signed({2'b00, vxvy_reg}) - $signed({2'b00, cc_reg});

    // products, then determinant, then split multiply, then sum
    always_ff @(posedge clk)
    begin
        vxvy_reg   <= var_x_reg * var_y_reg;
        cc_reg     <= cc_next;
        hh_reg     <= width_reg * width_reg;
        det_reg    <= det_next;
        hh2_reg    <= hh_reg;
        det_ok_reg <= !det_reg[33] && (det_reg != '0);
        plo_reg    <= det_reg[31:0] * hh2_reg[15:0];
        phi_reg    <= det_reg[31:0] * hh2_reg[31:16];
        denom_reg  <= {16'b0, plo_reg} + {phi_reg, 16'b0};
    end

    assign cfg.var_x  = var_x_reg;
    assign cfg.var_y  = var_y_reg;
    assign cfg.cov_xy = cov_xy_reg;
    assign cfg.denom  = denom_reg;
    assign cfg.det_ok = det_ok_reg;

endmodule

// ===== hdl/gkm_form.sv =====
// Quadratic form numerator x^2*vy - 2xy*c + y^2*vx over three stages.
module gkm_form (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  gkm_pkg::sample_t              sample,
    input  gkm_pkg::cfg_t                 cfg,
    output logic                          valid_out,
    output logic [gkm_pkg::NUM_BITS-1:0]  num
);
    import gkm_pkg::*;

    logic [2:0]          valid_reg;
    logic signed [31:0]  xx_reg, yy_reg, xy_reg;
    logic signed [47:0]  a_reg, cxy_reg, c_reg;
    logic signed [49:0]  nsig;
    logic [NUM_BITS-1:0] num_reg;

    assign nsig = 50'(a_reg) - (50'(cxy_reg) <<< 1) + 50'(c_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[1:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg  <= sample.offset_x * sample.offset_x;
            yy_reg  <= sample.offset_y * sample.offset_y;
            xy_reg  <= sample.offset_x * sample.offset_y;
            a_reg   <= xx_reg * $signed({1'b0, cfg.var_y});
            cxy_reg <= xy_reg * cfg.cov_xy;
            c_reg   <= yy_reg * $signed({1'b0, cfg.var_x});
            // clamp a negative form to zero
            num_reg <= nsig[49] ? '0 : nsig[NUM_BITS-1:0];
        end
    end

    assign valid_out = valid_reg[2];
    assign num       = num_reg;

endmodule

// ===== hdl/gkm_div.sv =====
// Restoring divider, one quotient bit per stage, plus special-case tagging.
module gkm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           valid_in,
    input  logic [gkm_pkg::NUM_BITS-1:0]   num,
    input  gkm_pkg::cfg_t                  cfg,
    output logic                           valid_out,
    output logic [gkm_pkg::QUOT_BITS-1:0]  quot,
    output gkm_pkg::tag_t                  tag
);
    import gkm_pkg::*;

    logic                 valid_reg [0:QUOT_BITS];
    logic [DEN_BITS-1:0]  rem_reg   [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] quot_reg  [0:QUOT_BITS];
    tag_t                 tag_reg   [0:QUOT_BITS];
    tag_t                 tag_next;
    logic                 den_zero, num_ge;

    assign den_zero = (cfg.denom == '0);
    assign num_ge   = ({16'b0, num} >= cfg.denom);

    always_comb
    begin
        tag_next.bad        = !cfg.det_ok;
        tag_next.force_zero = !cfg.det_ok || (den_zero && num != '0) || (!den_zero && num_ge);
        tag_next.force_full = cfg.det_ok && den_zero && num == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= {16'b0, num};
            quot_reg[0] <= '0;
            tag_reg[0]  <= tag_next;
        end
    end

    for (genvar i = 0; i < QUOT_BITS; i++)
    begin : g_step
        logic [DEN_BITS:0] shifted;
        logic              ge;

        assign shifted = {rem_reg[i], 1'b0};
        assign ge      = (shifted >= {1'b0, cfg.denom});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= ge ? DEN_BITS'(shifted - {1'b0, cfg.denom})
                                    : shifted[DEN_BITS-1:0];
                quot_reg[i+1] <= {quot_reg[i][QUOT_BITS-2:0], ge};
                tag_reg[i+1]  <= tag_reg[i];
            end
        end
    end

    assign valid_out = valid_reg[QUOT_BITS];
    assign quot      = quot_reg[QUOT_BITS];
    assign tag       = tag_reg[QUOT_BITS];

endmodule

// ===== hdl/gkm_exp.sv =====
// exp(-E): base-2 split, pipelined Taylor series, final scale and saturate.
module gkm_exp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  logic [gkm_pkg::QUOT_BITS-1:0] quot,
    input  gkm_pkg::tag_t                 tag,
    output logic                          valid_out,
    output gkm_pkg::result_t              result
);
    import gkm_pkg::*;

    // E1: t = E*log2(e)
    logic                 v1_reg;
    logic [39:0]          t_reg;
    tag_t                 tag1_reg;
    logic [61:0]          fprod;

    // Taylor pipeline, index 0 is the seed stage
    logic                 sv_reg   [0:TAYLOR_TERMS];
    logic [30:0]          term_reg [0:TAYLOR_TERMS];
    logic [31:0]          sum_reg  [0:TAYLOR_TERMS];
    logic [U_BITS-1:0]    u_reg    [0:TAYLOR_TERMS];
    logic [N_BITS-1:0]    n_reg    [0:TAYLOR_TERMS];
    tag_t                 tg_reg   [0:TAYLOR_TERMS];

    logic                 mv_reg   [1:TAYLOR_TERMS];
    logic [29:0]          v_reg    [1:TAYLOR_TERMS];
    logic [31:0]          msum_reg [1:TAYLOR_TERMS];
    logic [U_BITS-1:0]    mu_reg   [1:TAYLOR_TERMS];
    logic [N_BITS-1:0]    mn_reg   [1:TAYLOR_TERMS];
    tag_t                 mtg_reg  [1:TAYLOR_TERMS];

    logic                 out_valid_reg;
    result_t              result_reg;
    logic [RESULT_BITS-1:0] scaled;

    assign fprod = t_reg[31:0] * LN2_Q30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            sv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= valid_in;
            sv_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg       <= quot * LOG2E_Q16;
            tag1_reg    <= tag;
            u_reg[0]    <= fprod[61:32];
            n_reg[0]    <= t_reg[39:32];
            term_reg[0] <= 31'h4000_0000;
            sum_reg[0]  <= 32'h4000_0000;
            tg_reg[0]   <= tag1_reg;
        end
    end

    for (genvar k = 1; k <= TAYLOR_TERMS; k++)
    begin : g_term
        // floor(v/k) as (v*m)>>s, exact for v below 2^30
        localparam int SH = 30 + $clog2(k);
        localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(k) - 64'd1) / 64'(k);
        localparam logic [30:0] MUL = RECIP[30:0];

        logic [60:0] pmul;
        logic [60:0] pdiv;
        logic [29:0] term_next;

        assign pmul      = term_reg[k-1] * u_reg[k-1];
        assign pdiv      = v_reg[k] * MUL;
        assign term_next = 30'(pdiv >> SH);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mv_reg[k] <= 1'b0;
                sv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                mv_reg[k] <= sv_reg[k-1];
                sv_reg[k] <= mv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]    <= pmul[59:30];
                msum_reg[k] <= sum_reg[k-1];
                mu_reg[k]   <= u_reg[k-1];
                mn_reg[k]   <= n_reg[k-1];
                mtg_reg[k]  <= tg_reg[k-1];

                term_reg[k] <= {1'b0, term_next};
                sum_reg[k]  <= (k % 2 == 1) ? msum_reg[k] - {2'b0, term_next}
                                            : msum_reg[k] + {2'b0, term_next};
                u_reg[k]    <= mu_reg[k];
                n_reg[k]    <= mn_reg[k];
                tg_reg[k]   <= mtg_reg[k];
            end
        end
    end

    // scale by 2^-(30+n) into the result format, round half up, saturate
    always_comb
    begin
        int          sh;
        logic [63:0] r;
        sh = 30 + int'(n_reg[TAYLOR_TERMS]) - RESULT_BITS;
        r  = '0;
        if (n_reg[TAYLOR_TERMS] > N_BITS'(200) || sh > 62)
            r = '0;
        else if (sh > 0)
            r = ({32'b0, sum_reg[TAYLOR_TERMS]} + (64'd1 << (sh - 1))) >> sh;
        else
            r = {32'b0, sum_reg[TAYLOR_TERMS]} << (-sh);
        if (r > 64'((64'd1 << RESULT_BITS) - 64'd1))
            scaled = '1;
        else
            scaled = r[RESULT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= sv_reg[TAYLOR_TERMS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg.bad_covariance <= tg_reg[TAYLOR_TERMS].bad;
            if (tg_reg[TAYLOR_TERMS].force_zero)
                result_reg.kernel_value <= '0;
            else if (tg_reg[TAYLOR_TERMS].force_full)
                result_reg.kernel_value <= '1;
            else
                result_reg.kernel_value <= scaled;
        end
    end

    assign valid_out = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== hdl/gaussian_kernel_mahalanobis_2d.sv =====
// Top level of the streaming 2-D Mahalanobis Gaussian kernel evaluator.
//
//   channel   handshake                      payload
//   sample    sample_valid / sample_ready    sample (offset_x, offset_y)
//   result    result_valid / result_ready    result (kernel_value, bad_covariance)
//   config    cfg_write                      cfg_index, cfg_data
//
// One request enters per cycle while no result is held back; each result
// passes the quadratic form, the divider and exp, in that order.
// Reset clears the valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// A register write reaches the denominator via product, det, split-multiply, sum.
module gaussian_kernel_mahalanobis_2d (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  gkm_pkg::sample_t               sample,
    output logic                           result_valid,
    input  logic                           result_ready,
    output gkm_pkg::result_t               result,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [gkm_pkg::COORD_BITS-1:0] cfg_data
);
    import gkm_pkg::*;

    cfg_t                cfg;
    logic                en;
    logic                form_valid, div_valid;
    logic [NUM_BITS-1:0] num;
    logic [QUOT_BITS-1:0] quot;
    tag_t                tag;

    // advance every stage unless a finished result is held back
    assign en           = !result_valid || result_ready;
    assign sample_ready = en;

    gkm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // numerator of the quadratic form
    gkm_form u_form (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (sample_valid),
        .sample    (sample),
        .cfg       (cfg),
        .valid_out (form_valid),
        .num       (num)
    );

    // exponent N*2^23/(det*h^2), tagging the special cases
    gkm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (form_valid),
        .num       (num),
        .cfg       (cfg),
        .valid_out (div_valid),
        .quot      (quot),
        .tag       (tag)
    );

    // exp(-E) and output register
    gkm_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (div_valid),
        .quot      (quot),
        .tag       (tag),
        .valid_out (result_valid),
        .result    (result)
    );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench of the streaming 2-D Mahalanobis Gaussian kernel.
module tb;
    import gkm_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     sample_valid;
    logic     sample_ready;
    sample_t  sample;
    logic     result_valid;
    logic     result_ready;
    result_t  result;
    logic     cfg_write;
    logic [1:0] cfg_index;
    logic [COORD_BITS-1:0] cfg_data;

    gaussian_kernel_mahalanobis_2d u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Mirror of the block's registers, kept in step with every write.
    logic [COORD_BITS-1:0]        var_x_m;
    logic [COORD_BITS-1:0]        var_y_m;
    logic signed [COORD_BITS-1:0] cov_xy_m;
    logic [COORD_BITS-1:0]        width_m;

    sample_t pending_samples[$];
    result_t expected_kernels[$];

    int  mismatches;
    int  results_seen;
    int  bad_seen;
    int  phases_run;
    bit  quiet;          // no idling on either side once set
    bit  req_taken;      // a request was accepted at the last rising edge
    int  send_gap;
    int  recv_gap;

    initial begin
        clk = 1'b0;
        forever begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    // Kernel value of one offset under the mirrored registers.
    function automatic result_t kernel_of(sample_t s);
        longint      x, y, vx, vy, c, d, nsig;
        logic [63:0] num, h, b, r, q, t, n, f, u, term, sum, rounded;
        logic        top;
        int          i, sh;
        result_t     res;
        x  = s.offset_x;
        y  = s.offset_y;
        vx = {48'b0, var_x_m};
        vy = {48'b0, var_y_m};
        c  = cov_xy_m;
        d  = vx * vy - c * c;
        res.kernel_value   = '0;
        res.bad_covariance = 1'b0;
        if (d <= 0) begin
            res.bad_covariance = 1'b1;
            return res;
        end
        nsig = x * x * vy - 2 * x * y * c + y * y * vx;
        num  = (nsig < 0) ? 64'd0 : 64'(nsig);
        h    = {48'b0, width_m};
        b    = 64'(d) * h * h;
        if (b == 0) begin
            res.kernel_value = (num == 0) ? '1 : '0;
            return res;
        end
        if (num >= b)
            return res;
        // Restoring division of num * 2^23 by b.
        r = num;
        q = 0;
        for (i = 0; i < QUOT_BITS; i++) begin
            top = r[63];
            r   = r << 1;
            q   = q << 1;
            if (top || r >= b) begin
                r    = r - b;
                q[0] = 1'b1;
            end
        end
        // exp(-q): split into a power of two and a Taylor sum over the fraction.
        t    = q * 64'(LOG2E_Q16);
        n    = t >> 32;
        f    = {32'b0, t[31:0]};
        u    = (f * 64'(LN2_Q30)) >> 32;
        term = 64'd1 << 30;
        sum  = 64'd1 << 30;
        for (i = 1; i <= TAYLOR_TERMS; i++) begin
            term = ((term * u) >> 30) / 64'(i);
            if (i % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (n > 200)
            return res;
        sh = 30 + int'(n) - RESULT_BITS;
        if (sh > 62)
            return res;
        if (sh > 0)
            rounded = (sum + (64'd1 << (sh - 1))) >> sh;
        else
            rounded = sum << (-sh);
        res.kernel_value = (rounded > 64'hFFFF) ? '1 : rounded[RESULT_BITS-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input result_t got, input result_t want);
        $display("mismatch %s: got value %0d bad %0b, want value %0d bad %0b",
                 what, got.kernel_value, got.bad_covariance,
                 want.kernel_value, want.bad_covariance);
        mismatches++;
    endtask

    // Request side: record acceptance and predict the result at the edge itself.
    always @(posedge clk) begin
        req_taken = 1'b0;
        if (rst_n && sample_valid && sample_ready) begin
            expected_kernels.push_back(kernel_of(sample));
            req_taken = 1'b1;
        end
    end

    // Result side: compare every accepted result with the oldest expectation.
    always @(posedge clk) begin
        result_t want;
        if (rst_n && result_valid && result_ready) begin
            results_seen++;
            if (expected_kernels.size() == 0) begin
                report_mismatch("unexpected result", result, '0);
            end
            else begin
                want = expected_kernels.pop_front();
                if (result.bad_covariance) bad_seen++;
                if (result.kernel_value !== want.kernel_value)
                    report_mismatch("kernel_value", result, want);
                else if (result.bad_covariance !== want.bad_covariance)
                    report_mismatch("bad_covariance", result, want);
            end
        end
    end

    // Driver: hold a request until accepted, then advance or idle for a burst.
    always @(negedge clk) begin
        if (!rst_n) begin
            sample_valid <= 1'b0;
        end
        else if (!sample_valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                sample_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 2);
                sample_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0) begin
                sample       <= pending_samples.pop_front();
                sample_valid <= 1'b1;
            end
            else begin
                sample_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall in random bursts, none in the quiet part.
    always @(negedge clk) begin
        if (recv_gap > 0) begin
            recv_gap--;
            result_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 2);
            result_ready <= 1'b0;
        end
        else begin
            result_ready <= 1'b1;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [COORD_BITS-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_VAR_X:        var_x_m  = value;
            REG_VAR_Y:        var_y_m  = value;
            REG_COV_XY:       cov_xy_m = value;
            REG_KERNEL_WIDTH: width_m  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Load all four registers, then let the derived denominator settle.
    task automatic load_config(input logic [15:0] vx, input logic [15:0] vy,
                               input logic [15:0] c, input logic [15:0] h);
        write_reg(REG_VAR_X, vx);
        write_reg(REG_VAR_Y, vy);
        write_reg(REG_COV_XY, c);
        write_reg(REG_KERNEL_WIDTH, h);
        repeat (8) @(negedge clk);
        phases_run++;
    endtask

    // Wait for every expected result, then for the pipeline depth on top.
    task automatic drain;
        while (pending_samples.size() != 0 || sample_valid || expected_kernels.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic sample_t make_offset(input int span);
        sample_t s;
        if ($urandom_range(0, 9) < 6) begin
            s.offset_x = 16'($signed($urandom_range(0, 2 * span)) - span);
            s.offset_y = 16'($signed($urandom_range(0, 2 * span)) - span);
        end
        else begin
            s.offset_x = 16'($urandom);
            s.offset_y = 16'($urandom);
        end
        return s;
    endfunction

    task automatic queue_random(input int count);
        int span;
        repeat (count) begin
            span = 1 << $urandom_range(4, 12);
            pending_samples.push_back(make_offset(span));
        end
    endtask

    task automatic queue_pair(input logic [15:0] x, input logic [15:0] y);
        sample_t s;
        s.offset_x = x;
        s.offset_y = y;
        pending_samples.push_back(s);
    endtask

    initial begin
        logic [15:0] vx, vy, c, h;
        int          bound;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        result_ready = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        var_x_m      = 16'd256;
        var_y_m      = 16'd256;
        cov_xy_m     = 16'sd0;
        width_m      = 16'd256;
        mismatches   = 0;
        results_seen = 0;
        bad_seen     = 0;
        phases_run   = 0;
        quiet        = 1'b0;
        send_gap     = 0;
        recv_gap     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed offsets under reset values: origin, extremes, signs.
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'h0001, 16'h0000);
        queue_pair(16'h0100, 16'h0000);
        queue_pair(16'h0000, 16'hFF00);
        queue_pair(16'h0100, 16'h0100);
        queue_pair(16'h0300, 16'hFD00);
        queue_pair(16'h7FFF, 16'h7FFF);
        queue_pair(16'h8000, 16'h8000);
        queue_pair(16'h7FFF, 16'h8000);
        queue_pair(16'hFFFF, 16'h0001);
        queue_pair(16'h5555, 16'hAAAA);
        drain();

        // Not-positive determinant: zero, then negative.
        load_config(16'd16, 16'd16, 16'd16, 16'd256);
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'h0100, 16'h0200);
        drain();
        load_config(16'd1, 16'd1, 16'h8000, 16'd256);
        queue_pair(16'h7FFF, 16'h8000);
        queue_pair(16'h0000, 16'h0000);
        drain();

        // Widest variances with the smallest bandwidth, then the widest bandwidth.
        load_config(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'd1);
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'h0001, 16'h0001);
        queue_pair(16'h7FFF, 16'h8000);
        drain();
        load_config(16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF);
        queue_pair(16'h7FFF, 16'h7FFF);
        queue_pair(16'h8000, 16'h7FFF);
        queue_pair(16'h0400, 16'hFC00);
        queue_pair(16'h0000, 16'h0000);
        drain();

        // Random settings: mostly positive definite, some not, a few extremes.
        repeat (10) begin
            vx = 16'($urandom_range(1, 65535));
            vy = 16'($urandom_range(1, 65535));
            if (phases_run % 4 == 0) begin
                vx = 16'($urandom_range(1, 600));
                vy = 16'($urandom_range(1, 600));
            end
            bound = (vx < vy) ? vx : vy;
            c = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                            : 16'($signed($urandom_range(0, bound)) - bound / 2);
            h = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 8))
                                            : 16'($urandom_range(64, 2048));
            load_config(vx, vy, c, h);
            queue_random(100);
            drain();
        end

        // Back to reset values, no idling on either side.
        load_config(16'd256, 16'd256, 16'd0, 16'd256);
        quiet = 1'b1;
        queue_random(60);
        drain();

        $display("covered %0d register settings, %0d results, %0d with a bad covariance",
                 phases_run, results_seen, bad_seen);
        if (mismatches == 0)
            $display("[gaussian_kernel_mahalanobis_2d] OK");
        else
            $display("[gaussian_kernel_mahalanobis_2d] ERROR");
        $finish;
    end

    // Hard stop should the block hang.
    initial begin
        #3000000;
        $display("timed out with %0d results still owed", expected_kernels.size());
        $display("[gaussian_kernel_mahalanobis_2d] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/gkm_pkg.sv
hdl/gkm_cfg.sv
hdl/gkm_form.sv
hdl/gkm_div.sv
hdl/gkm_exp.sv
hdl/gaussian_kernel_mahalanobis_2d.sv
dv/tb.sv
